// File: rtl/core/lcdf_pkg.sv
// Shared types, constants and helpers of the LCD decimal field formatter.
package lcdf_pkg;

    // Characters per display row; the linear position is row * ROW_LENGTH + column
    localparam int ROW_LENGTH = 20;

    // Address register reset values
    localparam logic [6:0] LINE0_BASE_RST = 7'd0;
    localparam logic [6:0] LINE1_BASE_RST = 7'd64;
    localparam logic [6:0] LINE2_BASE_RST = 7'd20;
    localparam logic [6:0] LINE3_BASE_RST = 7'd84;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE0 = 2'd0;
    localparam logic [1:0] CFG_LINE1 = 2'd1;
    localparam logic [1:0] CFG_LINE2 = 2'd2;
    localparam logic [1:0] CFG_LINE3 = 2'd3;

    // Widths: clamped magnitude in thousandths, scaled magnitude (at most 99999)
    localparam int MAG_W = 27;
    localparam int NUM_W = 17;
    localparam int RCP_W = 28;
    localparam int PROD_W = MAG_W + RCP_W;

    // Reciprocals for exact truncating division over the ranges that reach them
    localparam logic [RCP_W-1:0] RECIP_10   = 28'd104858;
    localparam int               SHIFT_10   = 20;
    localparam logic [RCP_W-1:0] RECIP_100  = 28'd1342178;
    localparam int               SHIFT_100  = 27;
    localparam logic [RCP_W-1:0] RECIP_1000 = 28'd137438954;
    localparam int               SHIFT_1000 = 37;

    // Clamp limits on the magnitude in thousandths
    localparam logic [MAG_W-1:0] LIM_INT5_POS = 27'd99999999;
    localparam logic [MAG_W-1:0] LIM_INT5_NEG = 27'd9999999;
    localparam logic [MAG_W-1:0] LIM_F22_POS  = 27'd99990;
    localparam logic [MAG_W-1:0] LIM_F22_NEG  = 27'd9990;
    localparam logic [MAG_W-1:0] LIM_F21_POS  = 27'd99900;
    localparam logic [MAG_W-1:0] LIM_F21_NEG  = 27'd9900;
    localparam logic [MAG_W-1:0] LIM_F31_POS  = 27'd999900;
    localparam logic [MAG_W-1:0] LIM_F31_NEG  = 27'd99900;
    localparam logic [MAG_W-1:0] BIAS_TENTH   = 27'd5;
    localparam logic [MAG_W-1:0] BIAS_HUNDRED = 27'd50;
    localparam logic [7:0]       TWO_MAX      = 8'd99;

    // Display codes
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_POINT     = 8'h2E;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    typedef enum logic [2:0] {
        FMT_INT5 = 3'd0,
        FMT_F22  = 3'd1,
        FMT_F21  = 3'd2,
        FMT_F31  = 3'd3,
        FMT_TWO  = 3'd4
    } t_fmt;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_10,
        DIV_100,
        DIV_1000
    } t_div;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         char_pos;
        logic signed [27:0] value_milli;
    } t_in_beat;

    typedef struct packed {
        logic       is_command;
        logic [7:0] code;
        logic       last;
    } t_out_beat;

    // Control that rides along the pipeline with each item
    typedef struct packed {
        t_fmt       fmt;
        logic       neg;
        logic [6:0] addr;
    } t_fmt_ctl;

    typedef logic [4:0][3:0] t_digits;

    function automatic logic [NUM_W-1:0] pow10(input int k);
        logic [NUM_W-1:0] p;
        p = NUM_W'(1);
        for (int i = 0; i < k; i++) begin
            p = NUM_W'(p * NUM_W'(10));
        end
        return p;
    endfunction

endpackage

// File: rtl/core/lcdf_prep.sv
// Input register, row/column address and per-format clamp, magnitude and rounding bias.
module lcdf_prep import lcdf_pkg::*; #(
    parameter int ROW_LEN = ROW_LENGTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  t_in_beat              i_data,
    input  logic [3:0][6:0]       i_line_base,
    output logic                  o_valid,
    output logic [MAG_W-1:0]      o_y,
    output t_div                  o_div,
    output t_fmt_ctl              o_ctl
);

    localparam logic [6:0] ROW1 = 7'(ROW_LEN);
    localparam logic [6:0] ROW2 = 7'(2 * ROW_LEN);
    localparam logic [6:0] ROW3 = 7'(3 * ROW_LEN);

    logic             r_in_v;
    t_in_beat         r_in;
    logic             r_v;
    logic [MAG_W-1:0] r_y;
    t_div             r_div;
    t_fmt_ctl         r_ctl;

    logic               s_neg;
    logic [27:0]        mag;
    logic [MAG_W-1:0]   limit;
    logic [MAG_W-1:0]   bias;
    logic [MAG_W-1:0]   clamped;
    logic [1:0]         row;
    logic [6:0]         col;
    t_fmt               fmt;
    logic [MAG_W-1:0]   n_y;
    t_div               n_div;
    t_fmt_ctl           n_ctl;

    always_comb begin
        fmt   = t_fmt'(r_in.cmd);
        s_neg = r_in.value_milli[27];
        mag   = s_neg ? 28'(-r_in.value_milli) : 28'(r_in.value_milli);

        priority if (r_in.char_pos >= ROW3) begin
            row = 2'd3;
            col = r_in.char_pos - ROW3;
        end else if (r_in.char_pos >= ROW2) begin
            row = 2'd2;
            col = r_in.char_pos - ROW2;
        end else if (r_in.char_pos >= ROW1) begin
            row = 2'd1;
            col = r_in.char_pos - ROW1;
        end else begin
            row = 2'd0;
            col = r_in.char_pos;
        end

        n_ctl.fmt  = fmt;
        n_ctl.addr = i_line_base[row] + col;
        n_ctl.neg  = s_neg;
        limit      = '0;
        bias       = '0;
        n_div      = DIV_NONE;
        unique case (fmt)
            FMT_INT5: begin
                limit = s_neg ? LIM_INT5_NEG : LIM_INT5_POS;
                n_div = DIV_1000;
            end
            FMT_F22: begin
                limit = s_neg ? LIM_F22_NEG : LIM_F22_POS;
                bias  = BIAS_TENTH;
                n_div = DIV_10;
            end
            FMT_F21: begin
                limit     = s_neg ? LIM_F21_NEG : LIM_F21_POS;
                bias      = BIAS_HUNDRED;
                n_div     = DIV_100;
                n_ctl.neg = r_in.value_milli < -28'sd9;
            end
            FMT_F31: begin
                limit     = s_neg ? LIM_F31_NEG : LIM_F31_POS;
                bias      = BIAS_HUNDRED;
                n_div     = DIV_100;
                n_ctl.neg = r_in.value_milli < -28'sd9;
            end
            FMT_TWO: begin
                n_ctl.neg = 1'b0;
            end
            default: begin
                n_ctl.neg = 1'b0;
            end
        endcase

        clamped = (mag > {1'b0, limit}) ? limit : mag[MAG_W-1:0];
        if (fmt == FMT_TWO) begin
            n_y = (r_in.value_milli[7:0] > TWO_MAX) ? MAG_W'(TWO_MAX)
                                                    : MAG_W'(r_in.value_milli[7:0]);
        end else begin
            n_y = clamped + bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_v    <= 1'b0;
        end else if (i_adv) begin
            // drop unused format codes here: they make no results
            r_in_v <= i_valid && (i_data.cmd <= FMT_TWO);
            r_v    <= r_in_v;
        end
        if (i_adv) begin
            r_in  <= i_data;
            r_y   <= n_y;
            r_div <= n_div;
            r_ctl <= n_ctl;
        end
    end

    assign o_valid = r_v;
    assign o_y     = r_y;
    assign o_div   = r_div;
    assign o_ctl   = r_ctl;

endmodule

// File: rtl/core/lcdf_scale.sv
// Divide the biased magnitude by 10, 100 or 1000 by reciprocal multiply, or not.
module lcdf_scale import lcdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [MAG_W-1:0]  i_y,
    input  t_div              i_div,
    input  t_fmt_ctl          i_ctl,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_num,
    output t_fmt_ctl          o_ctl
);

    logic             r_v;
    logic [NUM_W-1:0] r_num;
    t_fmt_ctl         r_ctl;

    logic [RCP_W-1:0]  recip;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  n_num;

    always_comb begin
        unique case (i_div)
            DIV_10:   recip = RECIP_10;
            DIV_100:  recip = RECIP_100;
            DIV_1000: recip = RECIP_1000;
            default:  recip = '0;
        endcase
        prod = PROD_W'(i_y) * PROD_W'(recip);
        unique case (i_div)
            DIV_10:   n_num = prod[SHIFT_10 +: NUM_W];
            DIV_100:  n_num = prod[SHIFT_100 +: NUM_W];
            DIV_1000: n_num = prod[SHIFT_1000 +: NUM_W];
            default:  n_num = i_y[NUM_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_valid;
        end
        if (i_adv) begin
            r_num <= n_num;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_v;
    assign o_num   = r_num;
    assign o_ctl   = r_ctl;

endmodule

// File: rtl/core/lcdf_digits.sv
// Decimal digit split, one digit per pipeline stage, most significant first.
module lcdf_digits import lcdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  t_fmt_ctl          i_ctl,
    output logic              o_valid,
    output t_digits           o_dig,
    output t_fmt_ctl          o_ctl
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] r_v;
    t_fmt_ctl          r_ctl [STAGES];
    logic [NUM_W-1:0]  r_rem [STAGES];
    t_digits           r_dig [STAGES];

    logic [NUM_W-1:0]  src_rem [STAGES];
    t_digits           src_dig [STAGES];
    logic [NUM_W-1:0]  n_rem   [STAGES];
    t_digits           n_dig   [STAGES];
    logic [3:0]        dig     [STAGES];

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                src_rem[k] = i_num;
                src_dig[k] = '0;
            end else begin
                src_rem[k] = r_rem[k-1];
                src_dig[k] = r_dig[k-1];
            end
            // remainder is below ten times the weight, so nine compares find the digit
            dig[k] = '0;
            for (int j = 1; j < 10; j++) begin
                if (src_rem[k] >= NUM_W'(NUM_W'(j) * pow10(STAGES - k))) begin
                    dig[k] = 4'(j);
                end
            end
            n_rem[k] = src_rem[k] - NUM_W'(NUM_W'(dig[k]) * pow10(STAGES - k));
            n_dig[k] = src_dig[k];
            n_dig[k][3'(STAGES - k)] = dig[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
        if (i_adv) begin
            for (int k = 0; k < STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_dig[k] <= n_dig[k];
                r_ctl[k] <= (k == 0) ? i_ctl : r_ctl[k-1];
            end
        end
    end

    always_comb begin
        o_dig    = r_dig[STAGES-1];
        o_dig[0] = r_rem[STAGES-1][3:0];
    end

    assign o_valid = r_v[STAGES-1];
    assign o_ctl   = r_ctl[STAGES-1];

endmodule

// File: rtl/core/lcdf_emit.sv
// Build a field's bytes and shift out one result beat per cycle unless i_stall.
module lcdf_emit import lcdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_digits    i_dig,
    input  t_fmt_ctl   i_ctl,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_beat  o_data
);

    localparam int NBYTES = 6;

    logic [2:0]        r_left;
    logic [7:0]        r_code [NBYTES];
    logic [NBYTES-1:0] r_isc;

    logic [7:0]        n_code [NBYTES];
    logic [NBYTES-1:0] n_isc;
    logic [2:0]        n_cnt;
    logic [7:0]        cmd_byte;
    logic [7:0]        lead3;
    logic [7:0]        lead2;
    logic [7:0]        int_ch [5];
    logic              shown;
    logic              take;
    logic              load;

    function automatic logic [7:0] dg(input logic [3:0] d);
        return CH_ZERO | {4'd0, d};
    endfunction

    always_comb begin
        cmd_byte = CMD_SET_ADDR | {1'b0, i_ctl.addr};
        lead3 = (i_dig[3] != 4'd0) ? dg(i_dig[3]) : (i_ctl.neg ? CH_MINUS : CH_SPACE);
        lead2 = (i_dig[2] != 4'd0) ? dg(i_dig[2]) : (i_ctl.neg ? CH_MINUS : CH_SPACE);

        // integer field: blank leading zeros, minus just ahead of the first digit shown
        shown     = 1'b0;
        int_ch[0] = dg(i_dig[0]);
        for (int k = 4; k >= 1; k--) begin
            if (i_dig[k] != 4'd0 || shown) begin
                int_ch[k] = dg(i_dig[k]);
                shown     = 1'b1;
            end else if (i_ctl.neg && (i_dig[k-1] != 4'd0 || k == 1)) begin
                int_ch[k] = CH_MINUS;
            end else begin
                int_ch[k] = CH_SPACE;
            end
        end

        for (int i = 0; i < NBYTES; i++) begin
            n_code[i] = '0;
        end
        n_isc = '0;
        n_cnt = '0;
        unique case (i_ctl.fmt)
            FMT_INT5: begin
                n_code[0] = cmd_byte;
                n_code[1] = int_ch[4];
                n_code[2] = int_ch[3];
                n_code[3] = int_ch[2];
                n_code[4] = int_ch[1];
                n_code[5] = int_ch[0];
                n_isc     = 6'b000001;
                n_cnt     = 3'd6;
            end
            FMT_F22: begin
                n_code[0] = cmd_byte;
                n_code[1] = lead3;
                n_code[2] = dg(i_dig[2]);
                n_code[3] = CH_POINT;
                n_code[4] = dg(i_dig[1]);
                n_code[5] = dg(i_dig[0]);
                n_isc     = 6'b000001;
                n_cnt     = 3'd6;
            end
            FMT_F21: begin
                n_code[0] = cmd_byte;
                n_code[1] = lead2;
                n_code[2] = dg(i_dig[1]);
                n_code[3] = CH_POINT;
                n_code[4] = dg(i_dig[0]);
                n_isc     = 6'b000001;
                n_cnt     = 3'd5;
            end
            FMT_F31: begin
                n_code[0] = cmd_byte;
                n_code[1] = lead3;
                n_code[2] = dg(i_dig[2]);
                n_code[3] = dg(i_dig[1]);
                n_code[4] = CH_POINT;
                n_code[5] = dg(i_dig[0]);
                n_isc     = 6'b000001;
                n_cnt     = 3'd6;
            end
            FMT_TWO: begin
                n_code[0] = dg(i_dig[1]);
                n_code[1] = dg(i_dig[0]);
                n_cnt     = 3'd2;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign take    = (r_left != 3'd0) && !i_stall;
    assign o_ready = (r_left == 3'd0) || ((r_left == 3'd1) && !i_stall);
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= n_cnt;
        end else if (take) begin
            r_left <= r_left - 3'd1;
        end
        if (load) begin
            for (int i = 0; i < NBYTES; i++) begin
                r_code[i] <= n_code[i];
            end
            r_isc <= n_isc;
        end else if (take) begin
            for (int i = 0; i < NBYTES - 1; i++) begin
                r_code[i] <= r_code[i+1];
            end
            r_isc <= {1'b0, r_isc[NBYTES-1:1]};
        end
    end

    assign o_valid           = r_left != 3'd0;
    assign o_data.is_command = r_isc[0];
    assign o_data.code       = r_code[0];
    assign o_data.last       = r_left == 3'd1;

endmodule

// File: rtl/core/lcd_decimal_field_formatter_core.sv
// Top level of the LCD decimal field formatter.
//
// Turns one input beat (format, linear cursor position, signed value in
// thousandths) into the byte beats for a character LCD: a set-address command
// followed by five or four characters for the integer and fixed-point formats,
// or two digit characters for the two-digit format; last marks the final beat
// of an item, and format codes 5 to 7 are consumed without results. The path
// is a pipeline of registers: input register, clamp and rounding bias, a
// reciprocal multiply for the divide by 10, 100 or 1000, four stages that each
// take off one decimal digit, and a six-byte shift register that drives the
// output beats; an accepted input beat passes them in that order before its
// first result beat is presented. The input side takes a beat in any cycle
// in which the pipeline can advance; the sustained rate is set by the output,
// which sends one beat per cycle unless the receiver stalls; an item has six
// beats (five for fixed 2.1, two for the two-digit format). The next item
// is loaded into the output shift register in the same cycle the last beat
// of the previous one is taken. Row bases must be written through the
// configuration port while the block is idle; the block does not enforce it.
module lcd_decimal_field_formatter_core import lcdf_pkg::*; #(
    parameter int ROW_LEN = ROW_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_beat   i_data,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_beat  o_data,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    logic [3:0][6:0]  r_line_base;

    logic             adv;
    logic             prep_v;
    logic [MAG_W-1:0] prep_y;
    t_div             prep_div;
    t_fmt_ctl         prep_ctl;
    logic             scl_v;
    logic [NUM_W-1:0] scl_num;
    t_fmt_ctl         scl_ctl;
    logic             dig_v;
    t_digits          dig_val;
    t_fmt_ctl         dig_ctl;
    logic             emit_ready;

    // Row base registers: hold until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_base[0] <= LINE0_BASE_RST;
            r_line_base[1] <= LINE1_BASE_RST;
            r_line_base[2] <= LINE2_BASE_RST;
            r_line_base[3] <= LINE3_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE0: r_line_base[0] <= i_cfg_data;
                CFG_LINE1: r_line_base[1] <= i_cfg_data;
                CFG_LINE2: r_line_base[2] <= i_cfg_data;
                CFG_LINE3: r_line_base[3] <= i_cfg_data;
                default:   r_line_base[0] <= r_line_base[0];
            endcase
        end
    end

    // Advance the whole pipeline together unless a finished field waits for
    // the output shift register; a stall holds every stage, bubbles included.
    assign adv     = !dig_v || emit_ready;
    assign o_stall = !adv;

    lcdf_prep #(
        .ROW_LEN (ROW_LEN)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_line_base (r_line_base),
        .o_valid     (prep_v),
        .o_y         (prep_y),
        .o_div       (prep_div),
        .o_ctl       (prep_ctl)
    );

    lcdf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (prep_v),
        .i_y     (prep_y),
        .i_div   (prep_div),
        .i_ctl   (prep_ctl),
        .o_valid (scl_v),
        .o_num   (scl_num),
        .o_ctl   (scl_ctl)
    );

    lcdf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (scl_v),
        .i_num   (scl_num),
        .i_ctl   (scl_ctl),
        .o_valid (dig_v),
        .o_dig   (dig_val),
        .o_ctl   (dig_ctl)
    );

    lcdf_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dig_v),
        .i_dig   (dig_val),
        .i_ctl   (dig_ctl),
        .o_ready (emit_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// File: tb/sv/testbench.sv
// Testbench for the LCD decimal field formatter: predicted display bytes vs. DUT output.
`timescale 1ns / 1ps

module testbench import lcdf_pkg::*; ();

    // Display codes and limits, kept local to the predictor
    localparam logic [7:0] GLYPH_ZERO  = 8'h30;
    localparam logic [7:0] GLYPH_SPACE = 8'h20;
    localparam logic [7:0] GLYPH_MINUS = 8'h2D;
    localparam logic [7:0] GLYPH_POINT = 8'h2E;
    localparam logic [7:0] SET_ADDR    = 8'h80;
    localparam int         ROW_CHARS   = 20;
    localparam int         LAST_ROW    = 3;

    // Format codes with no meaning: the block swallows them
    localparam logic [2:0] FMT_RSVD_FIRST = 3'd5;
    localparam logic [2:0] FMT_RSVD_LAST  = 3'd7;

    localparam logic signed [27:0] VAL_MAX = 28'sh7FFFFFF;
    localparam logic signed [27:0] VAL_MIN = 28'sh8000000;

    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 1000; // cycles with no beat on either side

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_beat   i_data;
    logic       o_valid;
    logic       i_stall;
    t_out_beat  o_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    // Our own copy of the row bases and the bytes still owed by the DUT
    logic [6:0] row_base [4];
    t_out_beat  lcd_bytes_q [$];
    t_out_beat  want_byte;

    bit idle_on = 1'b1;
    int fail_cnt = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    lcd_decimal_field_formatter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Display byte predictor
    // ------------------------------------------------------------------

    function automatic t_out_beat lcd_byte(input bit is_cmd, input logic [7:0] code);
        t_out_beat ob;
        ob.is_command = is_cmd;
        ob.code       = code;
        ob.last       = 1'b0;
        return ob;
    endfunction

    // Round the dropped digit half-up and take it off
    function automatic longint round_off_digit(input longint mag);
        if (mag % 10 > 4) mag += 10;
        return mag / 10;
    endfunction

    // Top position: digit if nonzero, else the sign or a blank
    function automatic logic [7:0] lead_glyph(input int dig, input bit neg);
        if (dig != 0) return GLYPH_ZERO + 8'(dig);
        return neg ? GLYPH_MINUS : GLYPH_SPACE;
    endfunction

    // Work out the bytes one accepted item must produce and queue them
    function automatic void predict_field(input t_in_beat b);
        t_out_beat  field [$];
        t_out_beat  ob;
        longint     s;
        longint     c;
        longint     mag;
        int         d [5];
        bit         neg;
        bit         shown;
        int         row;
        int         col;
        logic [7:0] two;

        s = longint'($signed(b.value_milli));
        if (b.cmd > FMT_TWO) return;

        if (b.cmd == FMT_TWO) begin
            two = b.value_milli[7:0];
            if (two > 8'd99) two = 8'd99;
            field.push_back(lcd_byte(1'b0, GLYPH_ZERO + two / 8'd10));
            field.push_back(lcd_byte(1'b0, GLYPH_ZERO + two % 8'd10));
        end else begin
            row = int'(b.char_pos) / ROW_CHARS;
            if (row > LAST_ROW) row = LAST_ROW;
            col = int'(b.char_pos) - row * ROW_CHARS;
            field.push_back(lcd_byte(1'b1, SET_ADDR | {1'b0, 7'(int'(row_base[row]) + col)}));

            case (b.cmd)
                FMT_INT5: begin
                    // sign comes from the raw value, so -0.5 still shows a minus
                    neg = s < 0;
                    c = s / 1000;
                    if (c > 99999) c = 99999;
                    if (c < -9999) c = -9999;
                    mag = (c < 0) ? -c : c;
                end
                FMT_F22: begin
                    c = s;
                    if (c > 99990) c = 99990;
                    if (c < -9990) c = -9990;
                    neg = c < 0;
                    mag = round_off_digit((c < 0) ? -c : c);
                end
                FMT_F21: begin
                    c = s;
                    if (c > 99900) c = 99900;
                    if (c < -9900) c = -9900;
                    c = c / 10;   // sign is taken after truncation
                    neg = c < 0;
                    mag = round_off_digit((c < 0) ? -c : c);
                end
                default: begin
                    c = s;
                    if (c > 999900) c = 999900;
                    if (c < -99900) c = -99900;
                    c = c / 10;
                    neg = c < 0;
                    mag = round_off_digit((c < 0) ? -c : c);
                end
            endcase

            for (int k = 0; k < 5; k++) begin
                d[k] = int'(mag % 10);
                mag = mag / 10;
            end

            case (b.cmd)
                FMT_INT5: begin
                    // blank leading zeros; minus sits just left of the first digit
                    shown = 1'b0;
                    for (int k = 4; k >= 1; k--) begin
                        if (d[k] != 0 || shown) begin
                            field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[k])));
                            shown = 1'b1;
                        end else if (neg && (d[k-1] != 0 || k == 1)) begin
                            field.push_back(lcd_byte(1'b0, GLYPH_MINUS));
                        end else begin
                            field.push_back(lcd_byte(1'b0, GLYPH_SPACE));
                        end
                    end
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[0])));
                end
                FMT_F22: begin
                    field.push_back(lcd_byte(1'b0, lead_glyph(d[3], neg)));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[2])));
                    field.push_back(lcd_byte(1'b0, GLYPH_POINT));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[1])));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[0])));
                end
                FMT_F21: begin
                    field.push_back(lcd_byte(1'b0, lead_glyph(d[2], neg)));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[1])));
                    field.push_back(lcd_byte(1'b0, GLYPH_POINT));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[0])));
                end
                default: begin
                    field.push_back(lcd_byte(1'b0, lead_glyph(d[3], neg)));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[2])));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[1])));
                    field.push_back(lcd_byte(1'b0, GLYPH_POINT));
                    field.push_back(lcd_byte(1'b0, GLYPH_ZERO + 8'(d[0])));
                end
            endcase
        end

        // mark the final byte of the field
        ob = field.pop_back();
        ob.last = 1'b1;
        field.push_back(ob);
        foreach (field[i]) lcd_bytes_q.push_back(field[i]);
    endfunction

    // ------------------------------------------------------------------
    // Drivers (change at the falling edge)
    // ------------------------------------------------------------------

    // Send one input beat; returns at the falling edge after it was taken
    task automatic send_item(input logic [2:0] fmt, input logic [6:0] pos,
                             input logic signed [27:0] val);
        t_in_beat b;
        b.cmd         = fmt;
        b.char_pos    = pos;
        b.value_milli = val;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_data  = b;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_field(b);
        @(negedge i_clk);
    endtask

    // Drop valid, wait out every owed byte, then let the pipe settle
    task automatic wait_idle();
        i_valid = 1'b0;
        while (lcd_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_base(input logic [1:0] idx, input logic [6:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        row_base[idx] = val;
    endtask

    task automatic write_all_bases(input logic [6:0] b0, input logic [6:0] b1,
                                   input logic [6:0] b2, input logic [6:0] b3);
        write_base(CFG_LINE0, b0);
        write_base(CFG_LINE1, b1);
        write_base(CFG_LINE2, b2);
        write_base(CFG_LINE3, b3);
    endtask

    // Values spread over the interesting ranges of all formats
    function automatic logic signed [27:0] pick_value();
        longint v;
        case ($urandom_range(0, 5))
            0:       return 28'($urandom);
            1:       v = $urandom_range(0, 200000);
            2:       v = $urandom_range(0, 2000);
            3:       v = $urandom_range(9800, 10100);
            4:       v = $urandom_range(99800, 100100);
            default: v = $urandom_range(99990000, 100010000);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return 28'(v);
    endfunction

    function automatic logic [6:0] pick_position();
        if ($urandom_range(0, 4) == 0) return 7'($urandom_range(80, 127));
        return 7'($urandom_range(0, 79));
    endfunction

    // Random receiver stall, in bursts of random length
    always @(negedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            i_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Checker and watchdog (sample at the rising edge)
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (lcd_bytes_q.size() == 0) begin
                $error("byte with no field pending: code %02h", o_data.code);
                fail_cnt++;
            end else begin
                want_byte = lcd_bytes_q.pop_front();
                if (o_data.is_command !== want_byte.is_command) begin
                    $error("is_command: expected %0d, got %0d",
                           want_byte.is_command, o_data.is_command);
                    fail_cnt++;
                end
                if (o_data.code !== want_byte.code) begin
                    $error("code: expected %02h, got %02h", want_byte.code, o_data.code);
                    fail_cnt++;
                end
                if (o_data.last !== want_byte.last) begin
                    $error("last: expected %0d, got %0d", want_byte.last, o_data.last);
                    fail_cnt++;
                end
            end
        end
    end

    // Count cycles in which no beat moves on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes and special cases of each format at the reset row bases
    task automatic test_format_corners();
        send_item(FMT_INT5, 7'd0,  28'sd0);
        send_item(FMT_INT5, 7'd5,  VAL_MAX);           // clamps to 99999
        send_item(FMT_INT5, 7'd19, VAL_MIN);           // clamps to -9999
        send_item(FMT_INT5, 7'd20, -28'sd500);         // negative zero shows "-0"
        send_item(FMT_INT5, 7'd33, -28'sd1000);
        send_item(FMT_INT5, 7'd40, 28'sd12345678);
        send_item(FMT_F22,  7'd41, 28'sd99995);        // above the clamp
        send_item(FMT_F22,  7'd59, -28'sd9990);
        send_item(FMT_F22,  7'd60, -28'sd5);           // rounds up to -0.01
        send_item(FMT_F22,  7'd61, -28'sd4);           // rounds to zero, keeps sign
        send_item(FMT_F22,  7'd79, 28'sd1235);
        send_item(FMT_F21,  7'd80, -28'sd9);           // truncates to zero, no sign
        send_item(FMT_F21,  7'd99, 28'sd99950);
        send_item(FMT_F21,  7'd127, VAL_MIN);
        send_item(FMT_F21,  7'd2,  28'sd55);
        send_item(FMT_F31,  7'd3,  28'sd999999);
        send_item(FMT_F31,  7'd23, -28'sd150000);
        send_item(FMT_F31,  7'd44, 28'sd5050);         // second digit shows a zero
        send_item(FMT_TWO,  7'd0,  28'sd255);          // low byte clamps to 99
        send_item(FMT_TWO,  7'd0,  28'sd7);
        send_item(FMT_TWO,  7'd0,  -28'sd156);         // low byte 100
        send_item(FMT_RSVD_FIRST, 7'd0, 28'sd1234);    // swallowed
        send_item(FMT_RSVD_LAST,  7'd127, VAL_MAX);    // swallowed
        send_item(FMT_TWO,  7'd127, 28'sd99);
        wait_idle();
    endtask

    // Row boundaries and overflow past the last row under several base settings
    task automatic test_row_addressing();
        logic [6:0] edge_pos [8] = '{7'd0, 7'd19, 7'd20, 7'd39, 7'd40, 7'd60, 7'd79, 7'd127};
        for (int s = 0; s < 3; s++) begin
            case (s)
                0: write_all_bases(7'd0, 7'd0, 7'd0, 7'd0);
                1: write_all_bases(7'd127, 7'd127, 7'd127, 7'd127);
                default: write_all_bases(7'($urandom), 7'($urandom),
                                         7'($urandom), 7'($urandom));
            endcase
            foreach (edge_pos[i]) begin
                send_item(3'($urandom_range(int'(FMT_INT5), int'(FMT_F31))),
                          edge_pos[i], pick_value());
            end
            wait_idle();
        end
    endtask

    // Random formats, positions and values, with some swallowed codes mixed in
    task automatic test_random_fields(input int count);
        int sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(3'($urandom_range(int'(FMT_RSVD_FIRST), int'(FMT_RSVD_LAST))),
                          7'($urandom), 28'($urandom));
            end else begin
                send_item(3'($urandom_range(int'(FMT_INT5), int'(FMT_TWO))),
                          pick_position(), pick_value());
                sent++;
            end
            // change the row bases once midway, while the pipe is empty
            if (sent == count / 2) begin
                wait_idle();
                write_all_bases(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
                sent++;
            end
        end
        wait_idle();
    endtask

    // Back-to-back fields with no input gaps and no receiver stall
    task automatic test_streaming(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            send_item(3'($urandom_range(int'(FMT_INT5), int'(FMT_TWO))),
                      pick_position(), pick_value());
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        i_stall    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LINE0;
        i_cfg_data = '0;
        row_base[CFG_LINE0] = 7'd0;
        row_base[CFG_LINE1] = 7'd64;
        row_base[CFG_LINE2] = 7'd20;
        row_base[CFG_LINE3] = 7'd84;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_format_corners();
        test_row_addressing();
        test_random_fields(40);
        test_streaming(20);

        if (fail_cnt == 0 && lcd_bytes_q.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
